[rtl/core/lmts_pkg.sv]
// ----------------------------------------------------------------------------
// lmts_pkg
// Types, codes and timing constants shared by the LCD mode timing sequencer.
// ----------------------------------------------------------------------------
package lmts_pkg;

  // lcd modes
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  // configuration register indexes
  localparam int CfgAddrWidth = 3;
  localparam int CfgDataWidth = 8;
  typedef enum logic [CfgAddrWidth-1:0] {
    CFG_LCD_ON        = 3'd0,
    CFG_STAT_ENABLES  = 3'd1,
    CFG_LINE_COMPARE  = 3'd2,
    CFG_LAYER_ENABLES = 3'd3,
    CFG_SCROLL_Y      = 3'd4
  } cfg_index_t;

  // stat enable bit positions
  localparam int StatHblankBit = 0;
  localparam int StatVblankBit = 1;
  localparam int StatOamBit    = 2;
  localparam int StatLycBit    = 3;

  // layer enable bit positions
  localparam int LayerBgBit  = 0;
  localparam int LayerWinBit = 1;
  localparam int LayerObjBit = 2;

  // mode durations in machine cycles
  localparam logic [31:0] OamCycles     = 32'd80;
  localparam logic [31:0] XferCycles    = 32'd172;
  localparam logic [31:0] HblankCycles  = 32'd204;
  localparam logic [31:0] LineCycles    = 32'd456;
  localparam logic [31:0] VblankCycles  = 32'd4560;
  localparam logic [31:0] RefreshCycles = 32'd16384;

  localparam int VisibleLinesDefault = 144;

  // configuration registers
  typedef struct packed {
    logic       lcd_on;
    logic [3:0] stat_enables;
    logic [7:0] line_compare;
    logic [2:0] layer_enables;
    logic [7:0] scroll_y;
  } cfg_t;

  // sequencer state
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  line;
    logic [31:0] line_start;
    logic [31:0] vblank_start;
    logic [31:0] refresh_start;
    logic        powering_on;
    logic        coincidence;
  } state_t;

  // one result transaction
  typedef struct packed {
    logic [1:0] lcd_mode;
    logic [7:0] line_count;
    logic       vblank_irq;
    logic       stat_irq;
    logic       coincidence;
    logic       frame_present;
    logic       bg_line_request;
    logic [8:0] bg_line;
    logic       obj_line_request;
    logic       win_line_request;
  } result_t;

endpackage

[rtl/core/lmts_in_if.sv]
// ----------------------------------------------------------------------------
// lmts_in_if
// Input channel: one cycle-count sample per transaction.
// ----------------------------------------------------------------------------
interface lmts_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] clock_now;

  modport source (output valid, output clock_now, input ready);
  modport sink (input valid, input clock_now, output ready);
endinterface

[rtl/core/lmts_out_if.sv]
// ----------------------------------------------------------------------------
// lmts_out_if
// Result channel: mode, line, interrupt pulses and draw requests.
// ----------------------------------------------------------------------------
interface lmts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] lcd_mode;
  logic [7:0] line_count;
  logic       vblank_irq;
  logic       stat_irq;
  logic       coincidence;
  logic       frame_present;
  logic       bg_line_request;
  logic [8:0] bg_line;
  logic       obj_line_request;
  logic       win_line_request;

  modport source (
    output valid, output lcd_mode, output line_count, output vblank_irq,
    output stat_irq, output coincidence, output frame_present,
    output bg_line_request, output bg_line, output obj_line_request,
    output win_line_request, input ready
  );
  modport sink (
    input valid, input lcd_mode, input line_count, input vblank_irq,
    input stat_irq, input coincidence, input frame_present,
    input bg_line_request, input bg_line, input obj_line_request,
    input win_line_request, output ready
  );
endinterface

[rtl/core/lcd_mode_timing_sequencer.sv]
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer
// LCD mode and line sequencer driven by a free-running cycle count.
// ----------------------------------------------------------------------------
// path: an accepted sample is held in the input register, passed through the
//   combinational step logic and registered in the result register
// throughput: one transaction per cycle while results are taken; a full result
//   register that is not taken holds the input register and stalls the input
// reset: synchronous; state goes to oam search at line 0 with power-on set,
//   config to its defaults, both channels empty
module lcd_mode_timing_sequencer #(
  parameter int VISIBLE_LINES = lmts_pkg::VisibleLinesDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [lmts_pkg::CfgAddrWidth-1:0] cfg_addr,
  input  logic [lmts_pkg::CfgDataWidth-1:0] cfg_wdata,
  lmts_in_if.sink                           in_ch,
  lmts_out_if.source                        out_ch
);

  lmts_pkg::cfg_t    cfg;
  lmts_pkg::state_t  state;
  lmts_pkg::state_t  state_next;
  lmts_pkg::result_t res_next;
  lmts_pkg::result_t res;
  logic [31:0]       now;
  logic              in_full;
  logic              out_full;
  logic              advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lcd_on        <= 1'b1;
      cfg.stat_enables  <= 4'd0;
      cfg.line_compare  <= 8'd0;
      cfg.layer_enables <= 3'd1;
      cfg.scroll_y      <= 8'd0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        lmts_pkg::CFG_LCD_ON:        cfg.lcd_on        <= cfg_wdata[0];
        lmts_pkg::CFG_STAT_ENABLES:  cfg.stat_enables  <= cfg_wdata[3:0];
        lmts_pkg::CFG_LINE_COMPARE:  cfg.line_compare  <= cfg_wdata;
        lmts_pkg::CFG_LAYER_ENABLES: cfg.layer_enables <= cfg_wdata[2:0];
        lmts_pkg::CFG_SCROLL_Y:      cfg.scroll_y      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake control
  assign advance     = in_full && (!out_full || out_ch.ready);
  assign in_ch.ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ch.ready) begin
      in_full <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      now <= in_ch.clock_now;
    end
  end

  // step logic
  lmts_step #(
    .VISIBLE_LINES(VISIBLE_LINES)
  ) u_step (
    .now(now),
    .cfg(cfg),
    .cur(state),
    .nxt(state_next),
    .res(res_next)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode          <= lmts_pkg::MODE_OAM;
      state.line          <= 8'd0;
      state.line_start    <= 32'd0;
      state.vblank_start  <= 32'd0;
      state.refresh_start <= 32'd0;
      state.powering_on   <= 1'b1;
      state.coincidence   <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (out_ch.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  // result channel
  assign out_ch.valid            = out_full;
  assign out_ch.lcd_mode         = res.lcd_mode;
  assign out_ch.line_count       = res.line_count;
  assign out_ch.vblank_irq       = res.vblank_irq;
  assign out_ch.stat_irq         = res.stat_irq;
  assign out_ch.coincidence      = res.coincidence;
  assign out_ch.frame_present    = res.frame_present;
  assign out_ch.bg_line_request  = res.bg_line_request;
  assign out_ch.bg_line          = res.bg_line;
  assign out_ch.obj_line_request = res.obj_line_request;
  assign out_ch.win_line_request = res.win_line_request;

  // checks
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (in_full && out_full && !out_ch.ready))
    else $error("input stalled while result path is free");

  a_vblank_irq_mode: assert property (@(posedge clk) disable iff (rst)
    (out_full && res.vblank_irq) |-> (res.lcd_mode == lmts_pkg::MODE_VBLANK))
    else $error("vblank interrupt outside vblank");

  a_draw_req_mode: assert property (@(posedge clk) disable iff (rst)
    (out_full && (res.obj_line_request || res.win_line_request))
      |-> (res.lcd_mode == lmts_pkg::MODE_HBLANK))
    else $error("sprite or window request outside hblank");

  a_state_held: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without a transaction");

endmodule

[rtl/core/lmts_step.sv]
// ----------------------------------------------------------------------------
// lmts_step
// Next-state and result logic for one cycle-count sample.
// ----------------------------------------------------------------------------
module lmts_step #(
  parameter int VISIBLE_LINES = lmts_pkg::VisibleLinesDefault
) (
  input  logic [31:0]      now,
  input  lmts_pkg::cfg_t   cfg,
  input  lmts_pkg::state_t cur,
  output lmts_pkg::state_t nxt,
  output lmts_pkg::result_t res
);

  localparam logic [7:0] LastVisible = 8'(VISIBLE_LINES);

  logic [31:0] since_line;
  logic [31:0] since_vblank;
  logic [31:0] since_refresh;
  logic [7:0]  ly;
  logic        st_irq;
  logic        vb_irq;
  logic        present;
  logic        bg_req;
  logic        obj_req;
  logic        win_req;

  // elapsed cycles since each stamp, modulo 2^32
  assign since_line    = now - cur.line_start;
  assign since_vblank  = now - cur.vblank_start;
  assign since_refresh = now - cur.refresh_start;

  // mode stepping
  always_comb begin
    nxt     = cur;
    ly      = cur.line;
    st_irq  = 1'b0;
    vb_irq  = 1'b0;
    present = 1'b0;
    bg_req  = 1'b0;
    obj_req = 1'b0;
    win_req = 1'b0;
    unique case (cur.mode)
      lmts_pkg::MODE_HBLANK: begin
        if (since_line >= lmts_pkg::HblankCycles) begin
          ly = cur.line + 8'd1;
          if (ly >= LastVisible) begin
            nxt.mode         = lmts_pkg::MODE_VBLANK;
            nxt.vblank_start = now;
            nxt.refresh_start = now;
            st_irq  = cfg.stat_enables[lmts_pkg::StatVblankBit];
            vb_irq  = cfg.lcd_on;
            present = cfg.lcd_on && (since_refresh >= lmts_pkg::RefreshCycles);
          end else begin
            nxt.mode = lmts_pkg::MODE_OAM;
            st_irq   = cfg.stat_enables[lmts_pkg::StatOamBit];
          end
          nxt.line_start = now;
        end
      end
      lmts_pkg::MODE_VBLANK: begin
        if (since_line >= lmts_pkg::LineCycles) begin
          if (!cur.powering_on) ly = cur.line + 8'd1;
          nxt.line_start = now;
        end
        if (since_vblank >= lmts_pkg::VblankCycles) begin
          nxt.mode        = lmts_pkg::MODE_OAM;
          nxt.line_start  = now;
          nxt.powering_on = 1'b0;
          st_irq          = cfg.stat_enables[lmts_pkg::StatOamBit];
          ly              = 8'd0;
        end
      end
      lmts_pkg::MODE_OAM: begin
        if (since_line >= lmts_pkg::OamCycles) begin
          nxt.mode       = lmts_pkg::MODE_XFER;
          nxt.line_start = now;
          bg_req         = cfg.lcd_on && cfg.layer_enables[lmts_pkg::LayerBgBit];
        end
      end
      lmts_pkg::MODE_XFER: begin
        if (since_line >= lmts_pkg::XferCycles) begin
          nxt.mode       = lmts_pkg::MODE_HBLANK;
          nxt.line_start = now;
          st_irq         = cfg.stat_enables[lmts_pkg::StatHblankBit];
          obj_req        = cfg.lcd_on && cfg.layer_enables[lmts_pkg::LayerObjBit];
          win_req        = cfg.lcd_on && cfg.layer_enables[lmts_pkg::LayerWinBit];
        end
      end
      default: ;
    endcase

    // coincidence check on a line change
    if (ly != cur.line) begin
      if (cfg.lcd_on && (ly == cfg.line_compare)) begin
        nxt.coincidence = 1'b1;
        if (cfg.stat_enables[lmts_pkg::StatLycBit]) st_irq = 1'b1;
      end else begin
        nxt.coincidence = 1'b0;
      end
    end
    nxt.line = ly;
  end

  // result fields
  always_comb begin
    res.lcd_mode         = nxt.mode;
    res.line_count       = nxt.line;
    res.vblank_irq       = vb_irq;
    res.stat_irq         = st_irq;
    res.coincidence      = nxt.coincidence;
    res.frame_present    = present;
    res.bg_line_request  = bg_req;
    res.bg_line          = bg_req ? ({1'b0, cfg.scroll_y} + {1'b0, ly}) : 9'd0;
    res.obj_line_request = obj_req;
    res.win_line_request = win_req;
  end

endmodule

[tb/sv/lcd_timing_score_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_timing_score_pkg
// Scoreboard for the LCD mode timing sequencer: it follows the mode, line and
// stamp state for every accepted cycle-count sample, queues the result that
// sample must produce and checks each result transaction against it.
// ----------------------------------------------------------------------------
package lcd_timing_score_pkg;
  import lmts_pkg::*;

  class lcd_timing_score;
    // register copy and sequencer state
    cfg_t        regs;
    mode_t       mode;
    logic [7:0]  line;
    logic [31:0] line_start;
    logic [31:0] vblank_start;
    logic [31:0] refresh_start;
    logic        powering_on;
    logic        coinc;

    // results still owed by the block, oldest first
    result_t     pending_q[$];

    int unsigned checked;
    int unsigned mismatches;
    int unsigned vblank_count;
    int unsigned frame_count;
    int unsigned compare_hits;

    function new();
      regs.lcd_on        = 1'b1;
      regs.stat_enables  = 4'd0;
      regs.line_compare  = 8'd0;
      regs.layer_enables = 3'd1;
      regs.scroll_y      = 8'd0;
      mode          = MODE_OAM;
      line          = 8'd0;
      line_start    = 32'd0;
      vblank_start  = 32'd0;
      refresh_start = 32'd0;
      powering_on   = 1'b1;
      coinc         = 1'b0;
      checked       = 0;
      mismatches    = 0;
      vblank_count  = 0;
      frame_count   = 0;
      compare_hits  = 0;
    endfunction

    // mirror of one register write
    function void write_reg(cfg_index_t idx, logic [7:0] value);
      case (idx)
        CFG_LCD_ON:        regs.lcd_on        = value[0];
        CFG_STAT_ENABLES:  regs.stat_enables  = value[3:0];
        CFG_LINE_COMPARE:  regs.line_compare  = value;
        CFG_LAYER_ENABLES: regs.layer_enables = value[2:0];
        CFG_SCROLL_Y:      regs.scroll_y      = value;
        default: ;
      endcase
    endfunction

    function int unsigned waiting();
      return pending_q.size();
    endfunction

    // step the mode machine for one accepted sample and queue its result
    function void note_sample(logic [31:0] now);
      result_t    r;
      logic [7:0] ly;
      logic [7:0] ly_prev;
      logic       lcd;
      r       = '0;
      ly      = line;
      ly_prev = line;
      lcd     = regs.lcd_on;
      case (mode)
        MODE_HBLANK: begin
          if ((now - line_start) >= HblankCycles) begin
            ly = ly + 8'd1;
            if (ly >= VisibleLinesDefault) begin
              // last visible line done: into vblank
              mode         = MODE_VBLANK;
              vblank_start = now;
              vblank_count++;
              if (regs.stat_enables[StatVblankBit]) r.stat_irq = 1'b1;
              if (((now - refresh_start) >= RefreshCycles) && lcd) begin
                r.frame_present = 1'b1;
                frame_count++;
              end
              r.vblank_irq  = lcd;
              refresh_start = now;
            end else begin
              mode = MODE_OAM;
              if (regs.stat_enables[StatOamBit]) r.stat_irq = 1'b1;
            end
            line_start = now;
          end
        end
        MODE_VBLANK: begin
          // line steps and the end of vblank may land on the same sample
          if ((now - line_start) >= LineCycles) begin
            if (!powering_on) ly = ly + 8'd1;
            line_start = now;
          end
          if ((now - vblank_start) >= VblankCycles) begin
            mode        = MODE_OAM;
            line_start  = now;
            powering_on = 1'b0;
            if (regs.stat_enables[StatOamBit]) r.stat_irq = 1'b1;
            ly = 8'd0;
          end
        end
        MODE_OAM: begin
          if ((now - line_start) >= OamCycles) begin
            mode       = MODE_XFER;
            line_start = now;
            if (lcd && regs.layer_enables[LayerBgBit]) begin
              r.bg_line_request = 1'b1;
              r.bg_line         = {1'b0, regs.scroll_y} + {1'b0, ly};
            end
          end
        end
        default: begin
          if ((now - line_start) >= XferCycles) begin
            mode = MODE_HBLANK;
            if (regs.stat_enables[StatHblankBit]) r.stat_irq = 1'b1;
            if (lcd) begin
              r.obj_line_request = regs.layer_enables[LayerObjBit];
              r.win_line_request = regs.layer_enables[LayerWinBit];
            end
            line_start = now;
          end
        end
      endcase

      // coincidence is only re-evaluated when the line moves
      if (ly != ly_prev) begin
        if (lcd && (ly == regs.line_compare)) begin
          if (regs.stat_enables[StatLycBit]) r.stat_irq = 1'b1;
          coinc = 1'b1;
          compare_hits++;
        end else begin
          coinc = 1'b0;
        end
      end
      line = ly;

      r.lcd_mode    = mode;
      r.line_count  = line;
      r.coincidence = coinc;
      pending_q.push_back(r);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
               checked, field, got, want);
    endtask

    // compare one result transaction with the oldest queued result
    task check_result(result_t got);
      result_t want;
      if (pending_q.size() == 0) begin
        report("unexpected transaction", 32'(got), 32'd0);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.lcd_mode !== want.lcd_mode)
        report("lcd_mode", 32'(got.lcd_mode), 32'(want.lcd_mode));
      if (got.line_count !== want.line_count)
        report("line_count", 32'(got.line_count), 32'(want.line_count));
      if (got.vblank_irq !== want.vblank_irq)
        report("vblank_irq", 32'(got.vblank_irq), 32'(want.vblank_irq));
      if (got.stat_irq !== want.stat_irq)
        report("stat_irq", 32'(got.stat_irq), 32'(want.stat_irq));
      if (got.coincidence !== want.coincidence)
        report("coincidence", 32'(got.coincidence), 32'(want.coincidence));
      if (got.frame_present !== want.frame_present)
        report("frame_present", 32'(got.frame_present), 32'(want.frame_present));
      if (got.bg_line_request !== want.bg_line_request)
        report("bg_line_request", 32'(got.bg_line_request),
               32'(want.bg_line_request));
      if (got.bg_line !== want.bg_line)
        report("bg_line", 32'(got.bg_line), 32'(want.bg_line));
      if (got.obj_line_request !== want.obj_line_request)
        report("obj_line_request", 32'(got.obj_line_request),
               32'(want.obj_line_request));
      if (got.win_line_request !== want.win_line_request)
        report("win_line_request", 32'(got.win_line_request),
               32'(want.win_line_request));
    endtask
  endclass

endpackage

[tb/sv/tb_lcd_mode_timing_sequencer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcd_mode_timing_sequencer
// Drives cycle-count samples into the LCD mode timing sequencer through
// several register settings: a short hand-picked sequence, then mostly
// mode-by-mode advancing clocks with vblank line walks and random jumps.
// Both channels idle at random; one long result stall backs up the input.
// ----------------------------------------------------------------------------
module tb_lcd_mode_timing_sequencer;
  import lmts_pkg::*;
  import lcd_timing_score_pkg::*;

  localparam int PhaseCount  = 6;
  localparam int PhaseItems  = 225;
  localparam int HoldAt      = 300;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 8;
  localparam int LimitCycles = 400000;

  // hand-picked samples: exact thresholds, one short of them, and 2^32 wraps
  localparam logic [31:0] DirectedClocks [18] = '{
    32'd0, 32'd79, 32'd80, 32'd251, 32'd252, 32'd455, 32'd456, 32'd536,
    32'd708, 32'd912, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_00CC, 32'h8000_011C, 32'h8000_01C8, 32'h8000_02A0
  };

  logic                    clk;
  logic                    rst;
  logic                    cfg_wen;
  logic [CfgAddrWidth-1:0] cfg_addr;
  logic [CfgDataWidth-1:0] cfg_wdata;

  lmts_in_if  in_ch ();
  lmts_out_if out_ch ();

  lcd_mode_timing_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  lcd_timing_score score;

  bit          gaps_on;
  logic [31:0] now_q;
  int unsigned walk_left;
  bit          walk_high;
  int unsigned walked_vblank;
  int unsigned samples_sent;
  int unsigned results_seen;
  int unsigned phases_done;
  int unsigned cycle_count;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // one register write per clock; the caller lowers the write enable
  task automatic put_reg(input cfg_index_t idx, input logic [7:0] value);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    score.write_reg(idx, value);
  endtask

  task automatic program_regs(input cfg_t c);
    put_reg(CFG_LCD_ON, {7'd0, c.lcd_on});
    put_reg(CFG_STAT_ENABLES, {4'd0, c.stat_enables});
    put_reg(CFG_LINE_COMPARE, c.line_compare);
    put_reg(CFG_LAYER_ENABLES, {5'd0, c.layer_enables});
    put_reg(CFG_SCROLL_Y, c.scroll_y);
    cfg_wen <= 1'b0;
  endtask

  // offer one sample; valid stays high so back-to-back transactions need no gap
  task automatic offer_sample(input logic [31:0] value);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.clock_now <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    score.note_sample(value);
    samples_sent++;
  endtask

  // stop offering and wait for every owed result
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (score.waiting() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_value(input int unsigned top);
    case ($urandom_range(0, 2))
      0:       return 8'd0;
      1:       return top[7:0];
      default: return 8'($urandom_range(0, top));
    endcase
  endfunction

  function automatic cfg_t phase_setting(input int p);
    cfg_t c;
    case (p)
      0: begin
        c.lcd_on = 1'b1; c.stat_enables = 4'hF; c.line_compare = 8'd144;
        c.layer_enables = 3'd7; c.scroll_y = 8'd0;
      end
      1: begin
        c.lcd_on = 1'b0; c.stat_enables = 4'hF; c.line_compare = 8'd0;
        c.layer_enables = 3'd7; c.scroll_y = 8'hFF;
      end
      2: begin
        c.lcd_on = 1'b1; c.stat_enables = 4'h0; c.line_compare = 8'hFF;
        c.layer_enables = 3'd0; c.scroll_y = 8'h80;
      end
      default: begin
        c.lcd_on        = ($urandom_range(0, 3) != 0);
        c.stat_enables  = 4'(pick_value(15));
        c.line_compare  = $urandom_range(0, 1) ? 8'($urandom_range(0, 153))
                                               : pick_value(255);
        c.layer_enables = 3'(pick_value(7));
        c.scroll_y      = pick_value(255);
      end
    endcase
    return c;
  endfunction

  // next cycle count: mostly lands just past the current mode's threshold,
  // sometimes walks back and forth inside vblank so the line runs on and wraps
  function automatic logic [31:0] next_clock();
    int unsigned roll;
    logic [31:0] span;
    logic [31:0] spent;
    if (score.vblank_count != walked_vblank) begin
      walked_vblank = score.vblank_count;
      walk_left     = $urandom_range(0, 1) ? $urandom_range(20, 130) : 0;
    end
    if (walk_left != 0 && score.mode == MODE_VBLANK) begin
      walk_left--;
      walk_high = ~walk_high;
      now_q = score.vblank_start +
              (walk_high ? $urandom_range(2600, 4559) : $urandom_range(0, 1800));
      return now_q;
    end
    walk_left = 0;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      now_q = $urandom;
    end else if (roll < 10) begin
      now_q = now_q + $urandom_range(400, 5000);
    end else if (roll < 25) begin
      now_q = now_q + $urandom_range(0, 260);
    end else begin
      case (score.mode)
        MODE_OAM:    span = OamCycles;
        MODE_XFER:   span = XferCycles;
        MODE_HBLANK: span = HblankCycles;
        default:     span = LineCycles;
      endcase
      spent = now_q - score.line_start;
      now_q = now_q + ((spent < span) ? span - spent : 32'd0) + $urandom_range(0, 3);
    end
    return now_q;
  endfunction

  // stimulus and end of run
  initial begin
    cfg_t c;
    score = new();
    rst             <= 1'b1;
    cfg_wen         <= 1'b0;
    cfg_addr        <= CFG_LCD_ON;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.clock_now <= '0;
    gaps_on       = 1'b1;
    now_q         = 32'd0;
    walk_left     = 0;
    walk_high     = 1'b0;
    walked_vblank = 0;
    samples_sent  = 0;
    phases_done   = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: all stat causes on, compare at line 1, all layers, full scroll
    c.lcd_on = 1'b1; c.stat_enables = 4'hF; c.line_compare = 8'd1;
    c.layer_enables = 3'd7; c.scroll_y = 8'hFF;
    program_regs(c);
    foreach (DirectedClocks[i]) offer_sample(DirectedClocks[i]);
    now_q = DirectedClocks[17];
    drain();

    // random phases, registers rewritten only once the block has drained
    for (int p = 0; p < PhaseCount; p++) begin
      program_regs(phase_setting(p));
      gaps_on = (p != 1) && (p != 4);
      repeat (PhaseItems) offer_sample(next_clock());
      drain();
      phases_done++;
    end

    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d samples, %0d results checked over %0d register settings",
             samples_sent, score.checked, phases_done + 1);
    $display("saw %0d vblank entries, %0d frames presented, %0d line compare hits",
             score.vblank_count, score.frame_count, score.compare_hits);
    if (score.mismatches == 0 && score.waiting() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result side: random stalls plus one long hold to back up the input
  initial begin
    int unsigned gap;
    result_t     got;
    results_seen = 0;
    out_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (results_seen == HoldAt) gap = HoldCycles;
      else gap = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.lcd_mode         = out_ch.lcd_mode;
      got.line_count       = out_ch.line_count;
      got.vblank_irq       = out_ch.vblank_irq;
      got.stat_irq         = out_ch.stat_irq;
      got.coincidence      = out_ch.coincidence;
      got.frame_present    = out_ch.frame_present;
      got.bg_line_request  = out_ch.bg_line_request;
      got.bg_line          = out_ch.bg_line;
      got.obj_line_request = out_ch.obj_line_request;
      got.win_line_request = out_ch.win_line_request;
      score.check_result(got);
      results_seen++;
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count <= LimitCycles) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("watchdog expired after %0d cycles with %0d results outstanding",
             cycle_count, score.waiting());
    $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/lmts_pkg.sv
rtl/core/lmts_in_if.sv
rtl/core/lmts_out_if.sv
rtl/core/lmts_step.sv
rtl/core/lcd_mode_timing_sequencer.sv
tb/sv/lcd_timing_score_pkg.sv
tb/sv/tb_lcd_mode_timing_sequencer.sv
